### rtl/scpt_pkg.sv
`default_nettype none
package scpt_pkg;
   localparam int MaxCurves = 4;
   localparam int MaxPoints = 64;
   localparam int CurveW = $clog2(MaxCurves);
   localparam int PointW = $clog2(MaxPoints);
   localparam int CountW = $clog2(MaxPoints + 1);
   localparam int AddrW = CurveW + PointW;
   localparam int Depth = MaxCurves * MaxPoints;
   localparam logic [12:0] EpsMul = 13'd6711;
   localparam int EpsShift = 26;

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0, FUNC_SET = 3'd1, FUNC_GET = 3'd2, FUNC_COUNT = 3'd3,
      FUNC_DELETE = 3'd4, FUNC_CLEAR = 3'd5, FUNC_RSVD6 = 3'd6, FUNC_RSVD7 = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0, STATUS_BAD_INDEX = 2'd1, STATUS_FULL = 2'd2, STATUS_RSVD = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_CURVE_COUNT = 2'd0, CSR_RANGE_MIN = 2'd1, CSR_RANGE_MAX = 2'd2, CSR_NONE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SEARCH_RD, ST_SEARCH_WAIT, ST_SEARCH_CMP, ST_DECIDE,
      ST_SHIFT_RD, ST_SHIFT_WAIT, ST_SHIFT_WR, ST_WRITE, ST_GET_RD, ST_GET_WAIT,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;     // capture request, index = 0 for add, else point_index
      logic scan_up;       // index++
      logic scan_down;     // index--
      logic set_index_pi;  // index = point_index
      logic set_index_cnt; // index = count
      logic mem_rd;        // read at index (or index-1 / index+1 per rd_prev/rd_next)
      logic rd_prev;
      logic rd_next;
      logic mem_wr_shift;  // write latched read data at index
      logic mem_wr_entry;  // write new entry at index
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clear;
      logic take_get;      // latch get data into result
      logic set_pos;       // pos = index
      logic rsp_load;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic curve_bad;
      logic point_bad;     // point_index >= count
      logic scan_end;      // index >= count
      logic key_ge_lo;     // rd key >= k - eps
      logic key_le_hi;     // rd key <= k + eps
      logic full;          // count >= MaxPoints
      logic at_pos;        // index == pos + 1
      logic at_last;       // index + 1 >= count
      logic tail_done;     // index + 2 >= count
   } stat_type;
endpackage
`default_nettype wire

### rtl/scpt_req_if.sv
`default_nettype none
interface scpt_req_if;
   logic valid;
   logic ready;
   logic [2:0] func;
   logic [3:0] curve_index;
   logic [6:0] point_index;
   logic signed [31:0] point_key;
   logic signed [31:0] point_value;
   modport source (output valid, func, curve_index, point_index, point_key, point_value,
                   input ready);
   modport sink (input valid, func, curve_index, point_index, point_key, point_value,
                 output ready);
endinterface
`default_nettype wire

### rtl/scpt_rsp_if.sv
`default_nettype none
interface scpt_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic signed [31:0] key_out;
   logic signed [31:0] value_out;
   logic [6:0] count_out;
   modport source (output valid, status, key_out, value_out, count_out, input ready);
   modport sink (input valid, status, key_out, value_out, count_out, output ready);
endinterface
`default_nettype wire

### rtl/scpt_eps.sv
`default_nettype none
// Tolerance from the range registers: |max-min| * 6711 >> 26, registered.
module scpt_eps (
   input  wire logic clock,
   input  wire logic signed [31:0] range_min,
   input  wire logic signed [31:0] range_max,
   output logic [19:0] eps
);
   import scpt_pkg::*;
   logic signed [32:0] diff;
   logic [32:0] mag_in, mag_ff;
   logic [45:0] prod;
   logic [19:0] eps_in, eps_ff;

   assign diff = 33'(range_max) - 33'(range_min);
   assign mag_in = diff[32] ? 33'(-diff) : 33'(diff);
   assign prod = 46'(mag_ff) * 46'(EpsMul);
   assign eps_in = 20'(prod >> EpsShift);

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      eps_ff <= eps_in;
   end
   assign eps = eps_ff;
endmodule
`default_nettype wire

### rtl/scpt_datapath.sv
`default_nettype none
module scpt_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [2:0] curve_count,
   input  wire logic [19:0] eps,
   input  wire logic [2:0] func,
   input  wire logic [3:0] curve_index,
   input  wire logic [6:0] point_index,
   input  wire logic signed [31:0] point_key,
   input  wire logic signed [31:0] point_value,
   input  wire scpt_pkg::cmd_type cmd,
   output scpt_pkg::stat_type stat,
   output logic [1:0] status,
   output logic signed [31:0] key_out,
   output logic signed [31:0] value_out,
   output logic [6:0] count_out
);
   import scpt_pkg::*;

   logic [63:0] mem [Depth];
   logic [63:0] rd_ff;
   logic [2:0] func_ff;
   logic [3:0] ci_ff;
   logic [6:0] pi_ff;
   logic [63:0] entry_ff;
   logic signed [33:0] lo_ff, hi_ff;
   logic [CountW-1:0] counts_ff [MaxCurves];
   logic [CountW-1:0] idx_ff, idx_in, pos_ff;
   logic [CountW-1:0] cnt, cnt_next;
   logic [CurveW-1:0] cur;
   logic [CountW-1:0] rd_idx;
   logic signed [33:0] rkey;
   logic [1:0] status_ff;
   logic [31:0] kout_ff, vout_ff;
   logic [6:0] cout_ff;

   assign cur = ci_ff[CurveW-1:0];
   assign cnt = counts_ff[cur];
   assign rkey = 34'(signed'(rd_ff[63:32]));

   always_comb begin
      priority if (cmd.load_item)
         idx_in = (func_type'(func) == FUNC_ADD) ? '0 : CountW'(point_index);
      else if (cmd.set_index_pi) idx_in = CountW'(pi_ff);
      else if (cmd.set_index_cnt) idx_in = cnt;
      else if (cmd.scan_up) idx_in = idx_ff + 1'b1;
      else if (cmd.scan_down) idx_in = idx_ff - 1'b1;
      else idx_in = idx_ff;
   end

   always_comb begin
      priority if (cmd.rd_prev) rd_idx = idx_ff - 1'b1;
      else if (cmd.rd_next) rd_idx = idx_ff + 1'b1;
      else rd_idx = idx_ff;
   end

   always_comb begin
      priority if (cmd.cnt_clear) cnt_next = '0;
      else if (cmd.cnt_inc) cnt_next = cnt + 1'b1;
      else if (cmd.cnt_dec) cnt_next = cnt - 1'b1;
      else cnt_next = cnt;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_item) begin
         func_ff <= func;
         ci_ff <= curve_index;
         pi_ff <= point_index;
         entry_ff <= {point_key, point_value};
      end
      // bounds follow the held key and eps; settled well before the first compare
      lo_ff <= 34'(signed'(entry_ff[63:32])) - 34'(eps);
      hi_ff <= 34'(signed'(entry_ff[63:32])) + 34'(eps);
      if (cmd.set_pos) pos_ff <= idx_ff;
      if (cmd.mem_rd) rd_ff <= mem[{cur, rd_idx[PointW-1:0]}];
      if (cmd.mem_wr_shift) mem[{cur, idx_ff[PointW-1:0]}] <= rd_ff;
      else if (cmd.mem_wr_entry) mem[{cur, idx_ff[PointW-1:0]}] <= entry_ff;
      if (cmd.rsp_load) begin
         status_ff <= cmd.status;
         cout_ff <= stat.curve_bad ? 7'd0 : 7'(cnt_next);
         if (!cmd.take_get) begin
            kout_ff <= '0;
            vout_ff <= '0;
         end
      end
      if (cmd.take_get) begin
         kout_ff <= rd_ff[63:32];
         vout_ff <= rd_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MaxCurves; c++) counts_ff[c] <= '0;
      end else if (cmd.cnt_clear || cmd.cnt_inc || cmd.cnt_dec) begin
         counts_ff[cur] <= cnt_next;
      end
   end

   always_comb begin
      stat.func = func_type'(func_ff);
      stat.curve_bad = (ci_ff >= 4'(curve_count)) || (32'(ci_ff) >= MaxCurves);
      stat.point_bad = CountW'(pi_ff) >= cnt || 32'(pi_ff) >= MaxPoints;
      stat.scan_end = idx_ff >= cnt;
      stat.key_ge_lo = rkey >= lo_ff;
      stat.key_le_hi = rkey <= hi_ff;
      stat.full = 32'(cnt) >= MaxPoints;
      stat.at_pos = idx_ff == (pos_ff + 1'b1);
      stat.at_last = (idx_ff + 1'b1) >= cnt;
      stat.tail_done = (idx_ff + CountW'(2)) >= cnt;
   end

   assign status = status_ff;
   assign key_out = kout_ff;
   assign value_out = vout_ff;
   assign count_out = cout_ff;
endmodule
`default_nettype wire

### rtl/scpt_ctrl.sv
`default_nettype none
module scpt_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire scpt_pkg::stat_type stat,
   output scpt_pkg::cmd_type cmd
);
   import scpt_pkg::*;
   state_type state_ff, state_in;
   logic replace_ff, replace_in;
   logic valid_ff;
   logic rsp_done;

   assign rsp_done = cmd.rsp_load;

   always_comb begin
      state_in = state_ff;
      replace_in = replace_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.curve_bad) state_in = ST_RESP;
            else begin
               unique case (stat.func)
                  FUNC_ADD: state_in = stat.scan_end ? ST_DECIDE : ST_SEARCH_RD;
                  FUNC_SET: state_in = stat.point_bad ? ST_RESP : ST_WRITE;
                  FUNC_GET: state_in = stat.point_bad ? ST_RESP : ST_GET_RD;
                  FUNC_DELETE: state_in = stat.point_bad ? ST_RESP :
                                          (stat.at_last ? ST_RESP : ST_SHIFT_RD);
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH_RD: state_in = ST_SEARCH_WAIT;
         ST_SEARCH_WAIT: state_in = ST_SEARCH_CMP;
         ST_SEARCH_CMP: begin
            if (stat.key_ge_lo) begin
               replace_in = stat.key_le_hi;
               state_in = ST_DECIDE;
            end else state_in = ST_SEARCH_RD;
         end
         ST_DECIDE: begin
            if (replace_ff) state_in = ST_WRITE;
            else if (stat.full) state_in = ST_RESP;
            else if (stat.scan_end) state_in = ST_WRITE;
            else state_in = ST_SHIFT_RD;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WAIT;
         ST_SHIFT_WAIT: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (stat.func == FUNC_ADD) state_in = stat.at_pos ? ST_WRITE : ST_SHIFT_RD;
            else state_in = stat.tail_done ? ST_RESP : ST_SHIFT_RD;
         end
         ST_WRITE: state_in = ST_RESP;
         ST_GET_RD: state_in = ST_GET_WAIT;
         ST_GET_WAIT: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_SEARCH_CMP && !stat.key_ge_lo && stat.at_last) begin
         replace_in = 1'b0;
         state_in = ST_DECIDE;
      end
      if (state_ff == ST_CHECK) replace_in = 1'b0;
      if (state_ff == ST_RESP && valid_ff && !rsp_ready) state_in = ST_RESP;
   end

   // Search scans idx upward; at DECIDE idx is the position. Insert then sets
   // idx = count and walks down copying idx-1 to idx until idx == pos.
   // SHIFT_WR for add ends the copy when the written idx is pos + 1.
   always_comb begin
      cmd = '0;
      cmd.status = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: cmd.load_item = req_valid;
         ST_CHECK: begin
            if (stat.func == FUNC_SET || stat.func == FUNC_GET ||
                stat.func == FUNC_DELETE) cmd.set_index_pi = 1'b1;
         end
         ST_SEARCH_RD: cmd.mem_rd = 1'b1;
         ST_SEARCH_CMP: begin
            if (!stat.key_ge_lo) cmd.scan_up = 1'b1;
         end
         ST_DECIDE: begin
            cmd.set_pos = 1'b1;
            if (!replace_ff && !stat.full) cmd.set_index_cnt = 1'b1;
         end
         ST_SHIFT_RD: begin
            cmd.mem_rd = 1'b1;
            if (stat.func == FUNC_ADD) cmd.rd_prev = 1'b1;
            else cmd.rd_next = 1'b1;
         end
         ST_SHIFT_WR: begin
            cmd.mem_wr_shift = 1'b1;
            if (stat.func == FUNC_ADD) cmd.scan_down = 1'b1;
            else cmd.scan_up = 1'b1;
         end
         ST_WRITE: begin
            cmd.mem_wr_entry = 1'b1;
            if (stat.func == FUNC_ADD && !replace_ff) cmd.cnt_inc = 1'b1;
         end
         ST_GET_RD: cmd.mem_rd = 1'b1;
         ST_GET_WAIT: cmd.take_get = 1'b1;
         default: ;
      endcase
      if (state_ff == ST_CHECK && !stat.curve_bad) begin
         if (stat.func == FUNC_CLEAR) cmd.cnt_clear = 1'b1;
         if (stat.func == FUNC_DELETE && !stat.point_bad && stat.at_last)
            cmd.cnt_dec = 1'b1;
      end
      if (state_ff == ST_SHIFT_WR && stat.func == FUNC_DELETE && stat.tail_done)
         cmd.cnt_dec = 1'b1;
      if (state_in == ST_RESP && state_ff != ST_RESP) begin
         cmd.rsp_load = 1'b1;
         if (stat.curve_bad) cmd.status = STATUS_BAD_INDEX;
         else if (state_ff == ST_CHECK && stat.point_bad &&
                  (stat.func == FUNC_SET || stat.func == FUNC_GET ||
                   stat.func == FUNC_DELETE)) cmd.status = STATUS_BAD_INDEX;
         else if (state_ff == ST_DECIDE) cmd.status = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         replace_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         replace_ff <= replace_in;
         if (rsp_done) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

### rtl/sorted_control_point_table.sv
`default_nettype none
// Sorted control-point table: up to four curves of 64 (key, value) points in a
// single-port 256 x 64 memory. One item in, one result out; a new item is taken
// only after the last result has been accepted. Add scans from point 0 until the
// insert position, then shifts the tail up one point at a time; delete shifts the
// tail down one point at a time. Every scan and shift step goes through the one
// memory read port. Point memory is not cleared; counts reset to zero. Write range
// registers only while idle.
module sorted_control_point_table (
   input  wire logic clock,
   input  wire logic reset,
   scpt_req_if.sink req,
   scpt_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_write_data
);
   import scpt_pkg::*;
   logic [2:0] curve_count_ff;
   logic signed [31:0] range_min_ff, range_max_ff;
   logic [19:0] eps;
   cmd_type cmd;
   stat_type stat;
   logic [1:0] status;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_count_ff <= 3'd1;
         range_min_ff <= 32'sd0;
         range_max_ff <= 32'sd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CURVE_COUNT: curve_count_ff <= csr_write_data[2:0];
            CSR_RANGE_MIN: range_min_ff <= csr_write_data;
            CSR_RANGE_MAX: range_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   scpt_eps u_eps (.clock, .range_min(range_min_ff), .range_max(range_max_ff), .eps);

   scpt_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat, .cmd
   );

   scpt_datapath u_dp (
      .clock, .reset, .curve_count(curve_count_ff), .eps,
      .func(req.func), .curve_index(req.curve_index), .point_index(req.point_index),
      .point_key(req.point_key), .point_value(req.point_value),
      .cmd, .stat, .status, .key_out(rsp.key_out), .value_out(rsp.value_out),
      .count_out(rsp.count_out)
   );
   assign rsp.status = status;
endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
   import scpt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_CURVE_COUNT;
   logic [31:0] csr_write_data = '0;

   scpt_req_if req ();
   scpt_rsp_if rsp ();

   sorted_control_point_table dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      status_type status;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic [6:0] count;
   } result_type;

   // predictor state
   logic [63:0] table_mem [MaxCurves][MaxPoints];
   int unsigned table_len [MaxCurves];
   logic [2:0] curves_in_use;
   logic signed [31:0] lo_end, hi_end;

   result_type pending_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit random_stall = 1'b1;

   initial begin
      req.valid = 1'b0;
      req.func = FUNC_COUNT;
      req.curve_index = '0;
      req.point_index = '0;
      req.point_key = '0;
      req.point_value = '0;
      rsp.ready = 1'b0;
   end

   function automatic longint merge_eps();
      longint d;
      d = longint'(hi_end) - longint'(lo_end);
      if (d < 0) d = -d;
      return (d * 6711) >>> 26;
   endfunction

   function automatic result_type apply_op(logic [2:0] f, logic [3:0] ci, logic [6:0] pi,
                                           logic signed [31:0] k, logic signed [31:0] v);
      result_type r;
      int unsigned n, pos;
      longint e;
      r = '{STATUS_OK, 32'sd0, 32'sd0, 7'd0};
      if (ci >= curves_in_use || ci >= MaxCurves) begin
         r.status = STATUS_BAD_INDEX;
         return r;
      end
      n = table_len[ci];
      case (f)
         FUNC_ADD: begin
            e = merge_eps();
            pos = n;
            for (int i = 0; i < n; i++)
               if (longint'($signed(table_mem[ci][i][63:32])) >= longint'(k) - e) begin
                  pos = i;
                  break;
               end
            if (pos < n && longint'($signed(table_mem[ci][pos][63:32])) <= longint'(k) + e)
               table_mem[ci][pos] = {k, v};
            else if (n >= MaxPoints)
               r.status = STATUS_FULL;
            else begin
               for (int i = n; i > pos; i--) table_mem[ci][i] = table_mem[ci][i-1];
               table_mem[ci][pos] = {k, v};
               n++;
            end
         end
         FUNC_SET, FUNC_GET, FUNC_DELETE: begin
            if (pi >= n) r.status = STATUS_BAD_INDEX;
            else if (f == FUNC_SET) table_mem[ci][pi] = {k, v};
            else if (f == FUNC_GET) begin
               r.key = table_mem[ci][pi][63:32];
               r.value = table_mem[ci][pi][31:0];
            end else begin
               for (int i = pi; i + 1 < n; i++) table_mem[ci][i] = table_mem[ci][i+1];
               n--;
            end
         end
         FUNC_CLEAR: n = 0;
         default: ;
      endcase
      table_len[ci] = n;
      r.count = n[6:0];
      return r;
   endfunction

   // valid stays high into a back-to-back item; drain() drops it at the end
   task automatic send_item(logic [2:0] f, logic [3:0] ci, logic [6:0] pi,
                            logic signed [31:0] k, logic signed [31:0] v, bit gaps = 1'b1);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 9) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
         req.valid <= 1'b0;
         repeat (wait_n) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= f;
      req.curve_index <= ci;
      req.point_index <= pi;
      req.point_key <= k;
      req.point_value <= v;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(apply_op(f, ci, pi, k, v));
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CURVE_COUNT: curves_in_use = data[2:0];
         CSR_RANGE_MIN: lo_end = data;
         CSR_RANGE_MAX: hi_end = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: random, held or steady ready, checker
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_rsp) rsp.ready <= 1'b0;
      else if (random_stall) rsp.ready <= ($urandom_range(0, 9) < 6);
      else rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d", rsp.status);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp.status !== exp_r.status || rsp.key_out !== exp_r.key
                || rsp.value_out !== exp_r.value || rsp.count_out !== exp_r.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d k=%h v=%h n=%0d got st=%0d k=%h v=%h n=%0d",
                           exp_r.status, exp_r.key, exp_r.value, exp_r.count, rsp.status,
                           rsp.key_out, rsp.value_out, rsp.count_out);
            end
         end
      end
   end

   // watchdog on cycles without any request or result handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("sorted_control_point_table test failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(FUNC_COUNT, 0, 0, 0, 0);
      send_item(FUNC_GET, 0, 0, 0, 0);            // empty table
      send_item(FUNC_DELETE, 0, 0, 0, 0);
      send_item(FUNC_SET, 0, 0, 0, 0);
      send_item(FUNC_ADD, 1, 0, 0, 0);            // curve beyond curve_count
      send_item(FUNC_ADD, 15, 0, 0, 0);
      send_item(FUNC_ADD, 0, 0, 32'sh0001_0000, 32'sh1111_1111);
      send_item(FUNC_ADD, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff);
      send_item(FUNC_ADD, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000);
      send_item(FUNC_ADD, 0, 0, 32'sh0001_0003, 32'sh2222_2222);   // within eps: replace
      send_item(FUNC_ADD, 0, 0, 32'sh0000_8000, 32'sh3333_3333);
      send_item(FUNC_SET, 0, 1, 32'sh7fff_0000, 32'sh4444_4444);   // breaks order
      send_item(FUNC_ADD, 0, 0, 32'sh0000_4000, 32'sh5555_5555);
      for (int i = 0; i < 4; i++) send_item(FUNC_GET, 0, i[6:0], 0, 0);
      send_item(FUNC_GET, 0, 127, 0, 0);
      send_item(FUNC_DELETE, 0, 1, 0, 0);
      send_item(FUNC_RSVD6, 0, 0, 0, 0);
      send_item(FUNC_RSVD7, 0, 0, 0, 0);
      send_item(FUNC_CLEAR, 0, 0, 0, 0);
      send_item(FUNC_COUNT, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_full_table();
      write_csr(CSR_CURVE_COUNT, 32'd4);
      for (int i = 0; i < MaxPoints + 2; i++)
         send_item(FUNC_ADD, 3, 0, (i * 32'sh0001_0000) ^ 32'sh8000_0000, i, 1'b0);
      send_item(FUNC_ADD, 3, 0, 32'sh8000_0000, 32'sh0bad_0bad);  // replace on full
      send_item(FUNC_GET, 3, 63, 0, 0);
      send_item(FUNC_DELETE, 3, 0, 0, 0);
      send_item(FUNC_DELETE, 3, 62, 0, 0);
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_item(FUNC_COUNT, i[3:0] & 4'd3, 0, 0, 0, 1'b0);
      join
      drain();
   endtask

   task automatic test_random(int items);
      logic [2:0] f;
      logic [3:0] ci;
      int unsigned r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) f = FUNC_ADD;
         else if (r < 50) f = FUNC_SET;
         else if (r < 72) f = FUNC_GET;
         else if (r < 78) f = 3'($urandom_range(FUNC_COUNT, 7));
         else if (r < 93) f = FUNC_DELETE;
         else f = ($urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_COUNT;
         ci = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 3));
         random_stall = (i % 200) > 30;
         // half the keys from a small grid so tolerance merges happen
         send_item(f, ci,
                   ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, table_len[ci & 3] + 1)),
                   ($urandom_range(0, 1) == 0) ? $signed($urandom_range(0, 40) * 32'd6000)
                                               : rand_word(),
                   rand_word(), i % 200 > 30);
      end
      random_stall = 1'b1;
      drain();
   endtask

   initial begin
      curves_in_use = 3'd1;
      lo_end = 32'sd0;
      hi_end = 32'sd65536;
      foreach (table_len[c]) table_len[c] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      write_csr(CSR_RANGE_MIN, 32'h8000_0000);
      write_csr(CSR_RANGE_MAX, 32'h7fff_ffff);
      test_random(450);
      write_csr(CSR_RANGE_MIN, 32'h7fff_ffff);     // reversed range
      write_csr(CSR_RANGE_MAX, 32'hffff_0000);
      write_csr(CSR_CURVE_COUNT, 32'd3);
      test_random(450);
      write_csr(CSR_RANGE_MIN, 32'd5);
      write_csr(CSR_RANGE_MAX, 32'd5);             // zero tolerance
      write_csr(CSR_CURVE_COUNT, 32'd7);
      test_random(450);
      write_csr(CSR_CURVE_COUNT, 32'd0);
      test_random(30);
      write_csr(CSR_CURVE_COUNT, 32'd4);
      write_csr(CSR_RANGE_MIN, $urandom);
      write_csr(CSR_RANGE_MAX, $urandom);
      test_random(400);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("sorted_control_point_table test passed");
      else
         $display("sorted_control_point_table test failed");
      $finish;
   end
endmodule

### sorted_control_point_table.f
rtl/scpt_pkg.sv
rtl/scpt_req_if.sv
rtl/scpt_rsp_if.sv
rtl/scpt_eps.sv
rtl/scpt_datapath.sv
rtl/scpt_ctrl.sv
rtl/sorted_control_point_table.sv
tb/tb_top.sv
